@@ rtl/dbfd_pkg.sv @@
// ----------------------------------------------------------------------------
// dbfd_pkg
// Shared types, constants and helpers of the desktop bus frame decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package dbfd_pkg;

   localparam int COUNT_WIDTH = 16;
   localparam int CFG_WIDTH   = 16;
   localparam int CSR_INDEX_WIDTH = 3;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_WIDTH = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

   // Register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_RESET_MIN     = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ATTN_MIN      = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ATTN_MAX      = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BIT_THRESHOLD = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_HIGH_TIMEOUT  = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LOW_TIMEOUT   = 3'd5;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_RESP_WINDOW   = 3'd6;

   // Event kinds
   localparam logic [2:0] EV_RESET  = 3'd0;
   localparam logic [2:0] EV_CMD    = 3'd1;
   localparam logic [2:0] EV_DATA   = 3'd2;
   localparam logic [2:0] EV_NORESP = 3'd3;
   localparam logic [2:0] EV_FRAME  = 3'd4;

   // Command codes
   localparam logic [1:0] CMD_LISTEN = 2'd2;
   localparam logic [1:0] CMD_TALK   = 2'd3;

   typedef struct packed {
      logic [2:0]  kind;
      logic [7:0]  command;
      logic [15:0] data;
   } dbfd_event_type;

   typedef struct packed {
      logic [CFG_WIDTH-1:0] reset_min;
      logic [CFG_WIDTH-1:0] attn_min;
      logic [CFG_WIDTH-1:0] attn_max;
      logic [CFG_WIDTH-1:0] bit_threshold;
      logic [CFG_WIDTH-1:0] high_timeout;
      logic [CFG_WIDTH-1:0] low_timeout;
      logic [CFG_WIDTH-1:0] resp_window;
   } dbfd_cfg_type;

   function automatic logic [COUNT_WIDTH-1:0] count_up(input logic [COUNT_WIDTH-1:0] c);
      if (&c) begin
         return c;
      end
      return c + {{(COUNT_WIDTH-1){1'b0}}, 1'b1};
   endfunction

endpackage

`default_nettype wire

@@ rtl/desktop_bus_frame_decoder.sv @@
// ----------------------------------------------------------------------------
// desktop_bus_frame_decoder
// Single-wire desktop bus receiver: decodes reset pulses, attention and
// command bytes, data frames, missing Talk responses and framing errors.
// ----------------------------------------------------------------------------
// One line sample is taken per clock while full is low, so the block keeps
// up with a continuous sample stream at one sample per cycle. The decoder
// state machine finishes each sample in the cycle it is transferred; each
// decoded event goes into a four-entry queue and appears on the rsp_ ports
// once it reaches the queue head. full rises only when that queue holds
// four events that the consumer has not popped.
// ----------------------------------------------------------------------------
`default_nettype none

module desktop_bus_frame_decoder
   import dbfd_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       csr_write_enable,
   input  wire logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [CFG_WIDTH-1:0]       csr_write_data,
   input  wire logic                       push,
   output logic                            full,
   input  wire logic                       req_line_level,
   output logic                            empty,
   input  wire logic                       pop,
   output logic [2:0]                      rsp_event_kind,
   output logic [3:0]                      rsp_device_address,
   output logic [1:0]                      rsp_command_code,
   output logic [1:0]                      rsp_register_index,
   output logic [15:0]                     rsp_data_word
);

   logic           accept;
   logic           ev_valid;
   dbfd_event_type ev;

   assign accept = push & ~full;

   dbfd_decoder u_decoder (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .accept           (accept),
      .line_level       (req_line_level),
      .ev_valid         (ev_valid),
      .ev               (ev)
   );

   dbfd_event_queue u_queue (
      .clock          (clock),
      .reset          (reset),
      .wr_en          (ev_valid),
      .wr_event       (ev),
      .full           (full),
      .pop            (pop),
      .empty          (empty),
      .event_kind     (rsp_event_kind),
      .device_address (rsp_device_address),
      .command_code   (rsp_command_code),
      .register_index (rsp_register_index),
      .data_word      (rsp_data_word)
   );

endmodule

`default_nettype wire

@@ rtl/dbfd_decoder.sv @@
// ----------------------------------------------------------------------------
// dbfd_decoder
// Front end: registers the settings, takes one line sample per transfer and
// runs the frame state machine, producing at most one event per sample.
// ----------------------------------------------------------------------------
`default_nettype none

module dbfd_decoder
   import dbfd_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       csr_write_enable,
   input  wire logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [CFG_WIDTH-1:0]       csr_write_data,
   input  wire logic                       accept,
   input  wire logic                       line_level,
   output logic                            ev_valid,
   output dbfd_event_type                  ev
);

   localparam logic [3:0] PH_IDLE     = 4'd0;
   localparam logic [3:0] PH_ATTN     = 4'd1;
   localparam logic [3:0] PH_CMD_HI   = 4'd2;
   localparam logic [3:0] PH_CMD_LO   = 4'd3;
   localparam logic [3:0] PH_CSTOP_HI = 4'd4;
   localparam logic [3:0] PH_CSTOP_LO = 4'd5;
   localparam logic [3:0] PH_RESP     = 4'd6;
   localparam logic [3:0] PH_DATA_HI  = 4'd7;
   localparam logic [3:0] PH_DATA_LO  = 4'd8;
   localparam logic [3:0] PH_DSTOP_HI = 4'd9;
   localparam logic [3:0] PH_DSTOP_LO = 4'd10;

   localparam logic [COUNT_WIDTH-1:0] CNT_ZERO = '0;
   localparam logic [COUNT_WIDTH-1:0] CNT_ONE  = {{(COUNT_WIDTH-1){1'b0}}, 1'b1};

   dbfd_cfg_type cfg_ff;

   logic [3:0]             phase_ff, phase_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in, count_inc;
   logic [4:0]             bitpos_ff, bitpos_in, bitpos_inc;
   logic [15:0]            shift_ff, shift_in, shift_next;
   logic [7:0]             cmd_ff, cmd_in;
   logic                   prev_ff, prev_in;
   logic                   emit;
   logic [2:0]             emit_kind;
   logic [15:0]            emit_data;
   logic                   bit_one;
   logic [3:0]             after_cmd_phase;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.reset_min     <= 16'd3000;
         cfg_ff.attn_min      <= 16'd560;
         cfg_ff.attn_max      <= 16'd1040;
         cfg_ff.bit_threshold <= 16'd50;
         cfg_ff.high_timeout  <= 16'd200;
         cfg_ff.low_timeout   <= 16'd130;
         cfg_ff.resp_window   <= 16'd500;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_RESET_MIN:     cfg_ff.reset_min     <= csr_write_data;
            CSR_ATTN_MIN:      cfg_ff.attn_min      <= csr_write_data;
            CSR_ATTN_MAX:      cfg_ff.attn_max      <= csr_write_data;
            CSR_BIT_THRESHOLD: cfg_ff.bit_threshold <= csr_write_data;
            CSR_HIGH_TIMEOUT:  cfg_ff.high_timeout  <= csr_write_data;
            CSR_LOW_TIMEOUT:   cfg_ff.low_timeout   <= csr_write_data;
            CSR_RESP_WINDOW:   cfg_ff.resp_window   <= csr_write_data;
            default: ;
         endcase
      end
   end

   assign count_inc  = count_up(count_ff);
   assign bitpos_inc = bitpos_ff + 5'd1;
   assign bit_one    = (count_ff < cfg_ff.bit_threshold);
   assign shift_next = {shift_ff[14:0], bit_one};
   assign after_cmd_phase = (cmd_ff[3:2] == CMD_LISTEN || cmd_ff[3:2] == CMD_TALK) ?
                            PH_RESP : PH_IDLE;

   always_comb begin
      phase_in  = phase_ff;
      count_in  = count_ff;
      bitpos_in = bitpos_ff;
      shift_in  = shift_ff;
      cmd_in    = cmd_ff;
      prev_in   = line_level;
      emit      = 1'b0;
      emit_kind = EV_RESET;
      emit_data = 16'd0;
      case (phase_ff)
         PH_ATTN: begin
            if (!line_level) begin
               count_in = count_inc;
               if (count_inc >= cfg_ff.reset_min) begin
                  emit      = 1'b1;
                  emit_kind = EV_RESET;
                  phase_in  = PH_IDLE;
               end
            end else if (count_ff >= cfg_ff.attn_min && count_ff <= cfg_ff.attn_max) begin
               phase_in  = PH_CMD_HI;
               count_in  = CNT_ZERO;
               bitpos_in = 5'd0;
               shift_in  = 16'd0;
            end else begin
               phase_in = PH_IDLE;
            end
         end
         PH_CMD_HI, PH_DATA_HI: begin
            if (line_level) begin
               count_in = count_inc;
               if (count_inc >= cfg_ff.high_timeout) begin
                  emit      = 1'b1;
                  emit_kind = EV_FRAME;
                  phase_in  = PH_IDLE;
               end
            end else begin
               phase_in = phase_ff + 4'd1;
               count_in = CNT_ONE;
            end
         end
         PH_CMD_LO, PH_DATA_LO: begin
            if (!line_level) begin
               count_in = count_inc;
               if (count_inc >= cfg_ff.low_timeout) begin
                  emit      = 1'b1;
                  emit_kind = EV_FRAME;
                  phase_in  = PH_IDLE;
               end
            end else begin
               count_in = CNT_ZERO;
               if (phase_ff == PH_CMD_LO) begin
                  shift_in  = shift_next;
                  bitpos_in = bitpos_inc;
                  if (bitpos_inc >= 5'd8) begin
                     cmd_in    = shift_next[7:0];
                     emit      = 1'b1;
                     emit_kind = EV_CMD;
                     phase_in  = PH_CSTOP_HI;
                  end else begin
                     phase_in = PH_CMD_HI;
                  end
               end else if (bitpos_ff == 5'd0) begin
                  if (!bit_one) begin
                     emit      = 1'b1;
                     emit_kind = EV_FRAME;
                     phase_in  = PH_IDLE;
                  end else begin
                     bitpos_in = 5'd1;
                     shift_in  = 16'd0;
                     phase_in  = PH_DATA_HI;
                  end
               end else begin
                  shift_in = shift_next;
                  if (bitpos_ff >= 5'd16) begin
                     emit      = 1'b1;
                     emit_kind = EV_DATA;
                     emit_data = shift_next;
                     phase_in  = PH_DSTOP_HI;
                  end else begin
                     bitpos_in = bitpos_inc;
                     phase_in  = PH_DATA_HI;
                  end
               end
            end
         end
         PH_CSTOP_HI, PH_DSTOP_HI: begin
            if (line_level) begin
               count_in = count_inc;
               if (count_inc >= cfg_ff.high_timeout) begin
                  if (phase_ff == PH_CSTOP_HI) begin
                     count_in = CNT_ZERO;
                     phase_in = after_cmd_phase;
                  end else begin
                     phase_in = PH_IDLE;
                  end
               end
            end else begin
               phase_in = phase_ff + 4'd1;
               count_in = CNT_ONE;
            end
         end
         PH_CSTOP_LO, PH_DSTOP_LO: begin
            if (!line_level) begin
               count_in = count_inc;
               if (count_inc >= cfg_ff.low_timeout) begin
                  phase_in = PH_IDLE;
               end
            end else if (phase_ff == PH_CSTOP_LO) begin
               count_in = CNT_ZERO;
               phase_in = after_cmd_phase;
            end else begin
               phase_in = PH_IDLE;
            end
         end
         PH_RESP: begin
            if (line_level) begin
               count_in = count_inc;
               if (count_inc >= cfg_ff.resp_window) begin
                  if (cmd_ff[3:2] == CMD_TALK) begin
                     emit      = 1'b1;
                     emit_kind = EV_NORESP;
                  end
                  phase_in = PH_IDLE;
               end
            end else begin
               phase_in  = PH_DATA_LO;
               count_in  = CNT_ONE;
               bitpos_in = 5'd0;
               shift_in  = 16'd0;
            end
         end
         default: begin
            phase_in = PH_IDLE;
            if (prev_ff && !line_level) begin
               count_in = CNT_ONE;
               if (CNT_ONE >= cfg_ff.reset_min) begin
                  emit      = 1'b1;
                  emit_kind = EV_RESET;
               end else begin
                  phase_in = PH_ATTN;
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         count_ff  <= CNT_ZERO;
         bitpos_ff <= 5'd0;
         shift_ff  <= 16'd0;
         cmd_ff    <= 8'd0;
         prev_ff   <= 1'b1;
      end else if (accept) begin
         phase_ff  <= phase_in;
         count_ff  <= count_in;
         bitpos_ff <= bitpos_in;
         shift_ff  <= shift_in;
         cmd_ff    <= cmd_in;
         prev_ff   <= prev_in;
      end
   end

   assign ev_valid   = accept & emit;
   assign ev.kind    = emit_kind;
   assign ev.command = cmd_in;
   assign ev.data    = emit_data;

   assert property (@(posedge clock) disable iff (reset) ev_valid |-> accept)
      else $error("event without sample transfer");

   assert property (@(posedge clock) disable iff (reset)
      (ev_valid && ev.kind == EV_DATA) |-> (phase_ff == PH_DATA_LO && bitpos_ff >= 5'd16))
      else $error("data word event outside last data bit");

   assert property (@(posedge clock) disable iff (reset)
      (!reset && !accept) |=> ($stable(phase_ff) && $stable(count_ff)))
      else $error("decoder state moved without a transfer");

endmodule

`default_nettype wire

@@ rtl/dbfd_event_queue.sv @@
// ----------------------------------------------------------------------------
// dbfd_event_queue
// Back end: short event queue that holds decoded events until the consumer
// pops them, and formats the head entry onto the result fields.
// ----------------------------------------------------------------------------
`default_nettype none

module dbfd_event_queue
   import dbfd_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            wr_en,
   input  wire dbfd_event_type  wr_event,
   output logic                 full,
   input  wire logic            pop,
   output logic                 empty,
   output logic [2:0]           event_kind,
   output logic [3:0]           device_address,
   output logic [1:0]           command_code,
   output logic [1:0]           register_index,
   output logic [15:0]          data_word
);

   localparam logic [QUEUE_CNT_WIDTH-1:0] CNT_FULL  = QUEUE_CNT_WIDTH'(QUEUE_DEPTH);
   localparam logic [QUEUE_CNT_WIDTH-1:0] CNT_ONE   = QUEUE_CNT_WIDTH'(1);
   localparam logic [QUEUE_PTR_WIDTH-1:0] PTR_ONE   = QUEUE_PTR_WIDTH'(1);

   dbfd_event_type               slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_WIDTH-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_CNT_WIDTH-1:0]   count_ff, count_in;
   logic                         rd_en;
   dbfd_event_type               head;

   assign full  = (count_ff == CNT_FULL);
   assign empty = (count_ff == '0);
   assign rd_en = pop & ~empty;

   always_comb begin
      count_in = count_ff;
      if (wr_en && !rd_en) begin
         count_in = count_ff + CNT_ONE;
      end else if (rd_en && !wr_en) begin
         count_in = count_ff - CNT_ONE;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_ff[wr_ptr_ff] <= wr_event;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (wr_en) begin
            wr_ptr_ff <= wr_ptr_ff + PTR_ONE;
         end
         if (rd_en) begin
            rd_ptr_ff <= rd_ptr_ff + PTR_ONE;
         end
         count_ff <= count_in;
      end
   end

   assign head           = slot_ff[rd_ptr_ff];
   assign event_kind     = head.kind;
   assign device_address = head.command[7:4];
   assign command_code   = head.command[3:2];
   assign register_index = head.command[1:0];
   assign data_word      = head.data;

   assert property (@(posedge clock) disable iff (reset) wr_en |-> !full)
      else $error("event transfer into a full queue");

   assert property (@(posedge clock) disable iff (reset)
      (wr_ptr_ff - rd_ptr_ff) == count_ff[QUEUE_PTR_WIDTH-1:0])
      else $error("queue pointers disagree with fill count");

   assert property (@(posedge clock) disable iff (reset) count_ff <= CNT_FULL)
      else $error("queue fill count out of range");

endmodule

`default_nettype wire

@@ tb/tb_desktop_bus_frame_decoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_desktop_bus_frame_decoder
// Self-checking testbench for the desktop bus frame decoder. Line samples are
// built from command and data frames, reset pulses, broken frames and noise.
// A sample-by-sample decoder model predicts every event, and each popped event
// is checked field by field. Both queue sides idle and stall at random.
// ----------------------------------------------------------------------------

module tb_desktop_bus_frame_decoder;
   import dbfd_pkg::*;

   localparam int CYCLE_LIMIT  = 1000000;
   localparam int DRAIN_CYCLES = 8;

   localparam logic [1:0] CMD_RESET_CODE = 2'd0;
   localparam logic [1:0] CMD_FLUSH_CODE = 2'd1;

   typedef enum logic [3:0] {
      LINE_IDLE, LINE_ATTN, CMD_HIGH, CMD_LOW, CSTOP_HIGH, CSTOP_LOW,
      RESP_WAIT, DATA_HIGH, DATA_LOW, DSTOP_HIGH, DSTOP_LOW
   } line_phase_type;

   typedef enum int {
      FAULT_NONE, FAULT_BIT_LOW, FAULT_BIT_HIGH, FAULT_STOP_LOW, FAULT_STOP_HIGH,
      FAULT_START_ZERO
   } fault_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       csr_write_enable = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CFG_WIDTH-1:0]       csr_write_data = '0;
   logic                       push = 1'b0;
   logic                       full;
   logic                       req_line_level = 1'b1;
   logic                       empty;
   logic                       pop = 1'b0;
   logic [2:0]                 rsp_event_kind;
   logic [3:0]                 rsp_device_address;
   logic [1:0]                 rsp_command_code;
   logic [1:0]                 rsp_register_index;
   logic [15:0]                rsp_data_word;

   // decoder model state and its copy of the registers
   dbfd_cfg_type     timing;
   logic             line_prev;
   line_phase_type   line_phase;
   logic [15:0]      phase_ticks;
   logic [4:0]       bit_count;
   logic [15:0]      shift_reg;
   logic [7:0]       held_cmd;
   dbfd_event_type   pending_events[$];

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_off_cycles = 0;
   int samples_sent = 0;
   int events_predicted = 0;
   int mismatch_count = 0;
   int cycle_count = 0;

   desktop_bus_frame_decoder dut (
      .clock              (clock),
      .reset              (reset),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data),
      .push               (push),
      .full               (full),
      .req_line_level     (req_line_level),
      .empty              (empty),
      .pop                (pop),
      .rsp_event_kind     (rsp_event_kind),
      .rsp_device_address (rsp_device_address),
      .rsp_command_code   (rsp_command_code),
      .rsp_register_index (rsp_register_index),
      .rsp_data_word      (rsp_data_word)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d events outstanding", cycle_count,
                  pending_events.size());
         $display("Simulation FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------- model --

   function automatic logic [15:0] sat_inc(input logic [15:0] c);
      return (c == 16'hFFFF) ? c : c + 16'd1;
   endfunction

   task automatic post_event(input logic [2:0] kind, input logic [15:0] word);
      pending_events.push_back('{kind: kind, command: held_cmd, data: word});
      events_predicted++;
   endtask

   task automatic close_command;
      phase_ticks = '0;
      line_phase = (held_cmd[3:2] >= CMD_LISTEN) ? RESP_WAIT : LINE_IDLE;
   endtask

   task automatic decode_sample(input logic lvl);
      logic b;
      b = 1'b0;
      case (line_phase)
         LINE_ATTN: begin
            if (!lvl) begin
               phase_ticks = sat_inc(phase_ticks);
               if (phase_ticks >= timing.reset_min) begin
                  post_event(EV_RESET, 16'h0000);
                  line_phase = LINE_IDLE;
               end
            end else if (phase_ticks >= timing.attn_min &&
                         phase_ticks <= timing.attn_max) begin
               line_phase = CMD_HIGH;
               phase_ticks = '0;
               bit_count = '0;
               shift_reg = '0;
            end else begin
               line_phase = LINE_IDLE;
            end
         end
         CMD_HIGH, DATA_HIGH: begin
            if (lvl) begin
               phase_ticks = sat_inc(phase_ticks);
               if (phase_ticks >= timing.high_timeout) begin
                  post_event(EV_FRAME, 16'h0000);
                  line_phase = LINE_IDLE;
               end
            end else begin
               line_phase = (line_phase == CMD_HIGH) ? CMD_LOW : DATA_LOW;
               phase_ticks = 16'd1;
            end
         end
         CMD_LOW, DATA_LOW: begin
            if (!lvl) begin
               phase_ticks = sat_inc(phase_ticks);
               if (phase_ticks >= timing.low_timeout) begin
                  post_event(EV_FRAME, 16'h0000);
                  line_phase = LINE_IDLE;
               end
            end else begin
               b = (phase_ticks < timing.bit_threshold);
               phase_ticks = '0;
               if (line_phase == CMD_LOW) begin
                  shift_reg = {shift_reg[14:0], b};
                  bit_count = bit_count + 5'd1;
                  if (bit_count >= 5'd8) begin
                     held_cmd = shift_reg[7:0];
                     post_event(EV_CMD, 16'h0000);
                     line_phase = CSTOP_HIGH;
                  end else begin
                     line_phase = CMD_HIGH;
                  end
               end else if (bit_count == 5'd0) begin
                  // start bit of a data frame
                  if (!b) begin
                     post_event(EV_FRAME, 16'h0000);
                     line_phase = LINE_IDLE;
                  end else begin
                     bit_count = 5'd1;
                     shift_reg = '0;
                     line_phase = DATA_HIGH;
                  end
               end else begin
                  shift_reg = {shift_reg[14:0], b};
                  if (bit_count >= 5'd16) begin
                     post_event(EV_DATA, shift_reg);
                     line_phase = DSTOP_HIGH;
                  end else begin
                     bit_count = bit_count + 5'd1;
                     line_phase = DATA_HIGH;
                  end
               end
            end
         end
         CSTOP_HIGH, DSTOP_HIGH: begin
            if (lvl) begin
               phase_ticks = sat_inc(phase_ticks);
               if (phase_ticks >= timing.high_timeout) begin
                  if (line_phase == CSTOP_HIGH) close_command();
                  else line_phase = LINE_IDLE;
               end
            end else begin
               line_phase = (line_phase == CSTOP_HIGH) ? CSTOP_LOW : DSTOP_LOW;
               phase_ticks = 16'd1;
            end
         end
         CSTOP_LOW, DSTOP_LOW: begin
            if (!lvl) begin
               phase_ticks = sat_inc(phase_ticks);
               if (phase_ticks >= timing.low_timeout) line_phase = LINE_IDLE;
            end else if (line_phase == CSTOP_LOW) begin
               close_command();
            end else begin
               line_phase = LINE_IDLE;
            end
         end
         RESP_WAIT: begin
            if (lvl) begin
               phase_ticks = sat_inc(phase_ticks);
               if (phase_ticks >= timing.resp_window) begin
                  if (held_cmd[3:2] == CMD_TALK) post_event(EV_NORESP, 16'h0000);
                  line_phase = LINE_IDLE;
               end
            end else begin
               line_phase = DATA_LOW;
               phase_ticks = 16'd1;
               bit_count = '0;
               shift_reg = '0;
            end
         end
         default: begin
            line_phase = LINE_IDLE;
            if (line_prev && !lvl) begin
               phase_ticks = 16'd1;
               if (phase_ticks >= timing.reset_min) post_event(EV_RESET, 16'h0000);
               else line_phase = LINE_ATTN;
            end
         end
      endcase
      line_prev = lvl;
   endtask

   // -------------------------------------------------------------- checker --

   always @(posedge clock) begin
      dbfd_event_type want;
      if (!reset && pop && !empty) begin
         if (pending_events.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("%0t: unexpected event kind=%0d addr=%0h code=%0d reg=%0d data=%04h",
                        $realtime, rsp_event_kind, rsp_device_address, rsp_command_code,
                        rsp_register_index, rsp_data_word);
         end else begin
            want = pending_events.pop_front();
            if (rsp_event_kind !== want.kind || rsp_device_address !== want.command[7:4] ||
                rsp_command_code !== want.command[3:2] ||
                rsp_register_index !== want.command[1:0] || rsp_data_word !== want.data) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("%0t: mismatch expected kind=%0d addr=%0h code=%0d reg=%0d data=%04h",
                           $realtime, want.kind, want.command[7:4], want.command[3:2],
                           want.command[1:0], want.data);
                  $display("   got kind=%0d addr=%0h code=%0d reg=%0d data=%04h",
                           rsp_event_kind, rsp_device_address, rsp_command_code,
                           rsp_register_index, rsp_data_word);
               end
            end
         end
      end
   end

   // consumer side, pop changes at the falling edge
   initial begin
      forever begin
         @(negedge clock);
         if (hold_off_cycles > 0) begin
            pop = 1'b0;
            hold_off_cycles--;
         end else begin
            pop = ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // ------------------------------------------------------------- stimulus --

   function automatic int pick(input int lo, input int hi);
      if (hi <= lo) return lo;
      return $urandom_range(hi, lo);
   endfunction

   function automatic int bit_low(input logic b);
      return b ? pick(1, int'(timing.bit_threshold) - 1)
               : pick(int'(timing.bit_threshold), int'(timing.low_timeout) - 1);
   endfunction

   function automatic int bit_high();
      return pick(1, int'(timing.high_timeout));
   endfunction

   function automatic logic [15:0] random_word();
      case ($urandom_range(9))
         0: return 16'h0000;
         1: return 16'hFFFF;
         default: return 16'($urandom_range(65535));
      endcase
   endfunction

   // Called and left at a falling edge; push stays high after a transfer until an idle draw or a drain lowers it.
   task automatic send_sample(input logic lvl);
      while ($urandom_range(99) < send_idle_pct) begin
         push = 1'b0;
         @(negedge clock);
      end
      push = 1'b1;
      req_line_level = lvl;
      @(posedge clock);
      while (full) @(posedge clock);
      decode_sample(lvl);
      samples_sent++;
      @(negedge clock);
   endtask

   task automatic send_level(input logic lvl, input int n);
      repeat (n) send_sample(lvl);
   endtask

   task automatic wait_drained;
      push = 1'b0;
      while (pending_events.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_WIDTH-1:0] idx, input logic [15:0] value);
      csr_write_enable = 1'b1;
      csr_index = idx;
      csr_write_data = value;
      @(negedge clock);
      csr_write_enable = 1'b0;
      case (idx)
         CSR_RESET_MIN:     timing.reset_min = value;
         CSR_ATTN_MIN:      timing.attn_min = value;
         CSR_ATTN_MAX:      timing.attn_max = value;
         CSR_BIT_THRESHOLD: timing.bit_threshold = value;
         CSR_HIGH_TIMEOUT:  timing.high_timeout = value;
         CSR_LOW_TIMEOUT:   timing.low_timeout = value;
         CSR_RESP_WINDOW:   timing.resp_window = value;
         default: ;
      endcase
   endtask

   task automatic set_timing(input int rmin, input int amin, input int amax, input int thr,
                             input int hto, input int lto, input int win);
      wait_drained();
      write_reg(CSR_RESET_MIN, 16'(rmin));
      write_reg(CSR_ATTN_MIN, 16'(amin));
      write_reg(CSR_ATTN_MAX, 16'(amax));
      write_reg(CSR_BIT_THRESHOLD, 16'(thr));
      write_reg(CSR_HIGH_TIMEOUT, 16'(hto));
      write_reg(CSR_LOW_TIMEOUT, 16'(lto));
      write_reg(CSR_RESP_WINDOW, 16'(win));
   endtask

   // bit cells MSB first; a bit-cell fault cuts the frame short at a random bit
   task automatic send_bits(input logic [15:0] value, input int count, input fault_type fault,
                            output logic aborted);
      int spot;
      logic b;
      spot = pick(0, count - 1);
      aborted = 1'b0;
      for (int k = 0; k < count; k++) begin
         b = value[count - 1 - k];
         if (fault == FAULT_BIT_LOW && k == spot) begin
            send_level(1'b0, int'(timing.low_timeout) + pick(0, 2));
            send_level(1'b1, pick(2, 4));
            aborted = 1'b1;
            return;
         end
         send_level(1'b0, bit_low(b));
         if (fault == FAULT_BIT_HIGH && k == spot) begin
            send_level(1'b1, int'(timing.high_timeout) + pick(1, 3));
            aborted = 1'b1;
            return;
         end
         send_level(1'b1, bit_high());
      end
   endtask

   task automatic send_stop(input fault_type fault);
      case (fault)
         FAULT_STOP_LOW:  send_level(1'b0, int'(timing.low_timeout) + pick(0, 2));
         FAULT_STOP_HIGH: send_level(1'b1, int'(timing.high_timeout));
         default:         send_level(1'b0, pick(1, int'(timing.low_timeout) - 1));
      endcase
   endtask

   task automatic send_data_frame(input logic [15:0] word, input fault_type fault);
      logic aborted;
      if (fault == FAULT_START_ZERO) begin
         send_level(1'b0, pick(int'(timing.bit_threshold), int'(timing.low_timeout) - 1));
         send_level(1'b1, pick(2, 4));
      end else begin
         send_level(1'b0, bit_low(1'b1));
         send_level(1'b1, bit_high());
         send_bits(word, 16, fault, aborted);
         if (!aborted) begin
            send_stop(fault);
            send_level(1'b1, pick(2, 4));
         end
      end
   endtask

   task automatic send_transaction(input logic [7:0] cmd, input fault_type cmd_fault,
                                   input logic with_data, input logic [15:0] word,
                                   input fault_type data_fault);
      int attn_hi;
      logic aborted;
      attn_hi = int'(timing.attn_max);
      if (attn_hi > int'(timing.reset_min) - 1) attn_hi = int'(timing.reset_min) - 1;
      send_level(1'b1, pick(2, 4));
      send_level(1'b0, pick(int'(timing.attn_min), attn_hi));
      send_level(1'b1, bit_high());
      send_bits({8'h00, cmd}, 8, cmd_fault, aborted);
      if (aborted) return;
      send_stop(cmd_fault);
      if (with_data) begin
         send_level(1'b1, pick(1, int'(timing.resp_window)));
         send_data_frame(word, data_fault);
      end else begin
         send_level(1'b1, int'(timing.resp_window) + pick(1, 3));
      end
   endtask

   task automatic send_reset_pulse;
      send_level(1'b1, 2);
      send_level(1'b0, int'(timing.reset_min) + pick(0, 3));
      send_level(1'b1, 2);
   endtask

   task automatic send_bad_attention(input logic too_long);
      send_level(1'b1, 2);
      if (too_long)
         send_level(1'b0, pick(int'(timing.attn_max) + 1, int'(timing.reset_min) - 1));
      else
         send_level(1'b0, pick(1, int'(timing.attn_min) - 1));
      send_level(1'b1, pick(2, 6));
   endtask

   task automatic random_transfer_mix;
      int r;
      logic [7:0] cmd;
      fault_type fault;
      r = $urandom_range(99);
      cmd = 8'($urandom_range(255));
      fault = fault_type'($urandom_range(int'(FAULT_START_ZERO), int'(FAULT_BIT_LOW)));
      if (r < 55) begin
         send_transaction(cmd, FAULT_NONE, cmd[3:2] >= CMD_LISTEN && $urandom_range(3) != 0,
                          random_word(), FAULT_NONE);
      end else if (r < 70) begin
         if ($urandom_range(1)) begin
            cmd[3:2] = $urandom_range(1) ? CMD_TALK : CMD_LISTEN;
            send_transaction(cmd, FAULT_NONE, 1'b1, random_word(), fault);
         end else begin
            send_transaction(cmd, fault, 1'b0, 16'h0000, FAULT_NONE);
         end
      end else if (r < 78) begin
         send_reset_pulse();
      end else if (r < 86) begin
         send_bad_attention(1'($urandom_range(1)));
      end else begin
         repeat (pick(4, 24)) send_sample(1'($urandom_range(1)));
      end
   endtask

   // ---------------------------------------------------------------- tests --

   // line starts low right after reset, then short pulses well below attention
   task automatic test_power_on_defaults;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      send_level(1'b0, pick(4, 12));
      send_level(1'b1, 4);
      send_level(1'b0, pick(20, 40));
      send_level(1'b1, 4);
      wait_drained();
   endtask

   task automatic test_directed_frames;
      send_idle_pct = 25;
      recv_stall_pct = 25;
      set_timing(10, 2, 3, 2, 2, 3, 3);
      send_transaction({4'h0, CMD_RESET_CODE, 2'd0}, FAULT_NONE, 1'b0, 16'h0, FAULT_NONE);
      send_transaction({4'hF, CMD_FLUSH_CODE, 2'd3}, FAULT_NONE, 1'b0, 16'h0, FAULT_NONE);
      send_transaction({4'hA, CMD_TALK, 2'd2}, FAULT_NONE, 1'b1, 16'hFFFF, FAULT_NONE);
      send_transaction({4'h3, CMD_TALK, 2'd0}, FAULT_NONE, 1'b0, 16'h0, FAULT_NONE);
      send_transaction({4'h1, CMD_LISTEN, 2'd0}, FAULT_NONE, 1'b1, 16'h1234,
                       FAULT_START_ZERO);
      send_reset_pulse();
      send_bad_attention(1'b0);
      send_bad_attention(1'b1);
      wait_drained();
   endtask

   // all registers set to one: every falling edge is a bus reset
   task automatic test_output_backpressure;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      set_timing(1, 1, 1, 1, 1, 1, 1);
      hold_off_cycles = 300;
      repeat (20) begin
         send_sample(1'b1);
         send_sample(1'b0);
      end
      repeat (20) send_sample(1'($urandom_range(1)));
      wait_drained();
   endtask

   task automatic test_config_maximum;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      set_timing(65535, 65535, 65535, 65535, 65535, 65535, 65535);
      send_level(1'b1, 2);
      send_level(1'b0, pick(6, 16));
      send_level(1'b1, 4);
      wait_drained();
   endtask

   task automatic test_random_traffic;
      int send_pct[4];
      int stall_pct[4];
      int s0;
      int thr;
      int amin;
      int amax;
      send_pct = '{0, 65, 0, 25};
      stall_pct = '{0, 0, 65, 25};
      for (int p = 0; p < 4; p++) begin
         thr = pick(2, 3);
         amin = pick(2, 4);
         amax = amin + pick(0, 2);
         set_timing(amax + pick(2, 8), amin, amax, thr, pick(2, 4), thr + pick(1, 2),
                    pick(2, 6));
         send_idle_pct = send_pct[p];
         recv_stall_pct = stall_pct[p];
         s0 = samples_sent;
         while (samples_sent - s0 < 50) random_transfer_mix();
      end
      wait_drained();
   endtask

   initial begin
      timing = '{reset_min: 16'd3000, attn_min: 16'd560, attn_max: 16'd1040,
                 bit_threshold: 16'd50, high_timeout: 16'd200, low_timeout: 16'd130,
                 resp_window: 16'd500};
      line_prev = 1'b1;
      line_phase = LINE_IDLE;
      phase_ticks = '0;
      bit_count = '0;
      shift_reg = '0;
      held_cmd = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_power_on_defaults();
      test_directed_frames();
      test_output_backpressure();
      test_config_maximum();
      test_random_traffic();

      wait_drained();
      if (mismatch_count == 0 && pending_events.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

@@ files.f @@
rtl/dbfd_pkg.sv
rtl/dbfd_decoder.sv
rtl/dbfd_event_queue.sv
rtl/desktop_bus_frame_decoder.sv
tb/tb_desktop_bus_frame_decoder.sv
